// ----- hw/rtl/whcp_pkg.sv -----
// ----------------------------------------------------------------------------
// whcp_pkg
// shared types and constants for the riff/wave header parser
// ----------------------------------------------------------------------------
package whcp_pkg;

    localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
    localparam logic [31:0] FMT_MIN_BYTES  = 32'd16;
    localparam logic [15:0] PCM_FORMAT     = 16'd1;
    localparam logic [15:0] PCM_BITS       = 16'd16;

    // chunk and file ids as they appear little endian in the stream
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    typedef enum logic [1:0] {
        PHASE_RIFF   = 2'd0,
        PHASE_HEADER = 2'd1,
        PHASE_BODY   = 2'd2,
        PHASE_PAD    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_FMT   = 2'd1,
        KIND_DATA  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_NOT_PCM   = 3'd3,
        ST_NO_DATA   = 3'd4,
        ST_BAD_BITS  = 3'd5
    } t_status;

    // parse state as it stands after the final byte
    typedef struct packed {
        logic        len_short;
        logic        magic_good;
        logic        format_error;
        logic        data_found;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [31:0] data_offset;
        logic [31:0] data_size;
    } t_summary;

    typedef struct packed {
        t_status     status;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] bits_per_sample;
        logic [31:0] pcm_offset;
        logic [31:0] pcm_bytes;
    } t_result;

endpackage

// ----- hw/rtl/whcp_walker.sv -----
// ----------------------------------------------------------------------------
// whcp_walker
// per-byte chunk walk: magic check, header capture, body skip, fmt capture
// ----------------------------------------------------------------------------
module whcp_walker
    import whcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_summary   o_summary
);

    logic [31:0] r_pos,       n_pos;
    t_phase      r_phase,     n_phase;
    logic [63:0] r_hdr,       n_hdr;
    logic [2:0]  r_fill,      n_fill;
    t_kind       r_kind,      n_kind;
    logic [32:0] r_chunk_end, n_chunk_end;
    logic [31:0] r_body_start, n_body_start;
    logic [4:0]  r_cnt,       n_cnt;
    logic        r_magic,     n_magic;
    logic        r_stopped,   n_stopped;
    logic [15:0] r_pfmt,      n_pfmt;
    logic [15:0] r_pch,       n_pch;
    logic [31:0] r_prate,     n_prate;
    logic [15:0] r_pbits,     n_pbits;
    logic [15:0] r_kch,       n_kch;
    logic [31:0] r_krate,     n_krate;
    logic [15:0] r_kbits,     n_kbits;
    logic [31:0] r_doff,      n_doff;
    logic [31:0] r_dsize,     n_dsize;
    logic        r_dfound,    n_dfound;
    logic        r_fmt_err,   n_fmt_err;

    logic [32:0] pos_inc;
    logic [63:0] hdr_base;
    logic        commit;

    assign pos_inc  = {1'b0, r_pos} + 33'd1;
    assign hdr_base = (r_fill == 3'd0) ? 64'd0 : r_hdr;

    always_comb begin
        n_pos        = r_pos;
        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_fill       = r_fill;
        n_kind       = r_kind;
        n_chunk_end  = r_chunk_end;
        n_body_start = r_body_start;
        n_cnt        = r_cnt;
        n_magic      = r_magic;
        n_stopped    = r_stopped;
        n_pfmt       = r_pfmt;
        n_pch        = r_pch;
        n_prate      = r_prate;
        n_pbits      = r_pbits;
        n_kch        = r_kch;
        n_krate      = r_krate;
        n_kbits      = r_kbits;
        n_doff       = r_doff;
        n_dsize      = r_dsize;
        n_dfound     = r_dfound;
        n_fmt_err    = r_fmt_err;
        commit       = 1'b0;

        if (i_en) begin
            n_pos = pos_inc[31:0];
        end

        if (i_en && !r_stopped) begin
            unique case (r_phase)
                PHASE_RIFF: begin
                    if (r_pos < 32'd4) begin
                        if (i_byte != ID_RIFF[{r_pos[1:0], 3'b000} +: 8]) begin
                            n_magic = 1'b0;
                        end
                    end else if (r_pos >= 32'd8 && r_pos < 32'd12) begin
                        if (i_byte != ID_WAVE[{r_pos[1:0], 3'b000} +: 8]) begin
                            n_magic = 1'b0;
                        end
                    end
                    if (r_pos >= 32'd11) begin
                        n_phase = PHASE_HEADER;
                        n_fill  = 3'd0;
                    end
                end
                PHASE_HEADER: begin
                    n_hdr  = hdr_base | ({56'd0, i_byte} << {r_fill, 3'b000});
                    n_fill = r_fill + 3'd1;
                    if (r_fill == 3'd7) begin
                        n_chunk_end  = pos_inc + {1'b0, n_hdr[63:32]};
                        n_body_start = pos_inc[31:0];
                        n_cnt        = 5'd0;
                        if (n_hdr[31:0] == ID_FMT && n_hdr[63:32] >= FMT_MIN_BYTES) begin
                            n_kind = KIND_FMT;
                        end else if (n_hdr[31:0] == ID_DATA) begin
                            n_kind = KIND_DATA;
                        end else begin
                            n_kind = KIND_OTHER;
                        end
                        n_pfmt  = 16'd0;
                        n_pch   = 16'd0;
                        n_prate = 32'd0;
                        n_pbits = 16'd0;
                        if (n_hdr[63:32] == 32'd0) begin
                            commit = 1'b1;
                        end else begin
                            n_phase = PHASE_BODY;
                        end
                    end
                end
                PHASE_BODY: begin
                    if (!r_cnt[4]) begin
                        n_cnt = r_cnt + 5'd1;
                        if (r_kind == KIND_FMT) begin
                            case (r_cnt[3:0])
                                4'd0:    n_pfmt[7:0]    = i_byte;
                                4'd1:    n_pfmt[15:8]   = i_byte;
                                4'd2:    n_pch[7:0]     = i_byte;
                                4'd3:    n_pch[15:8]    = i_byte;
                                4'd4:    n_prate[7:0]   = i_byte;
                                4'd5:    n_prate[15:8]  = i_byte;
                                4'd6:    n_prate[23:16] = i_byte;
                                4'd7:    n_prate[31:24] = i_byte;
                                4'd14:   n_pbits[7:0]   = i_byte;
                                4'd15:   n_pbits[15:8]  = i_byte;
                                default: ;
                            endcase
                        end
                    end
                    if (pos_inc == r_chunk_end) begin
                        commit  = 1'b1;
                        n_phase = r_hdr[32] ? PHASE_PAD : PHASE_HEADER;
                    end
                end
                PHASE_PAD: begin
                    n_phase = PHASE_HEADER;
                end
                default: begin
                    n_phase = PHASE_HEADER;
                end
            endcase

            // a counted chunk updates the kept fmt or data fields
            if (commit) begin
                if (n_kind == KIND_FMT) begin
                    n_kch   = n_pch;
                    n_krate = n_prate;
                    n_kbits = n_pbits;
                    if (n_pfmt != PCM_FORMAT) begin
                        n_fmt_err = 1'b1;
                        n_stopped = 1'b1;
                    end
                end else if (n_kind == KIND_DATA) begin
                    n_doff   = n_body_start;
                    n_dsize  = n_hdr[63:32];
                    n_dfound = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_summary.len_short    = (r_pos < (MIN_FILE_BYTES - 32'd1));
        o_summary.magic_good   = n_magic;
        o_summary.format_error = n_fmt_err;
        o_summary.data_found   = n_dfound;
        o_summary.channels     = n_kch;
        o_summary.rate         = n_krate;
        o_summary.bits         = n_kbits;
        o_summary.data_offset  = n_doff;
        o_summary.data_size    = n_dsize;
    end

    // the final byte of a file returns everything to the reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos        <= 32'd0;
            r_phase      <= PHASE_RIFF;
            r_hdr        <= 64'd0;
            r_fill       <= 3'd0;
            r_kind       <= KIND_OTHER;
            r_chunk_end  <= 33'd0;
            r_body_start <= 32'd0;
            r_cnt        <= 5'd0;
            r_magic      <= 1'b1;
            r_stopped    <= 1'b0;
            r_pfmt       <= 16'd0;
            r_pch        <= 16'd0;
            r_prate      <= 32'd0;
            r_pbits      <= 16'd0;
            r_kch        <= 16'd0;
            r_krate      <= 32'd0;
            r_kbits      <= 16'd0;
            r_doff       <= 32'd0;
            r_dsize      <= 32'd0;
            r_dfound     <= 1'b0;
            r_fmt_err    <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_phase      <= n_phase;
            r_hdr        <= n_hdr;
            r_fill       <= n_fill;
            r_kind       <= n_kind;
            r_chunk_end  <= n_chunk_end;
            r_body_start <= n_body_start;
            r_cnt        <= n_cnt;
            r_magic      <= n_magic;
            r_stopped    <= n_stopped;
            r_pfmt       <= n_pfmt;
            r_pch        <= n_pch;
            r_prate      <= n_prate;
            r_pbits      <= n_pbits;
            r_kch        <= n_kch;
            r_krate      <= n_krate;
            r_kbits      <= n_kbits;
            r_doff       <= n_doff;
            r_dsize      <= n_dsize;
            r_dfound     <= n_dfound;
            r_fmt_err    <= n_fmt_err;
        end
    end

endmodule

// ----- hw/rtl/whcp_result.sv -----
// ----------------------------------------------------------------------------
// whcp_result
// status priority encode and field zeroing on failure
// ----------------------------------------------------------------------------
module whcp_result
    import whcp_pkg::*;
(
    input  t_summary i_summary,
    output t_result  o_result
);

    t_status status;

    always_comb begin
        if (i_summary.len_short) begin
            status = ST_SHORT;
        end else if (!i_summary.magic_good) begin
            status = ST_BAD_MAGIC;
        end else if (i_summary.format_error) begin
            status = ST_NOT_PCM;
        end else if (!i_summary.data_found || i_summary.data_size == 32'd0) begin
            status = ST_NO_DATA;
        end else if (i_summary.bits != PCM_BITS) begin
            status = ST_BAD_BITS;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.channel_count   = i_summary.channels;
            o_result.rate_hz         = i_summary.rate;
            o_result.bits_per_sample = i_summary.bits;
            o_result.pcm_offset      = i_summary.data_offset;
            o_result.pcm_bytes       = i_summary.data_size;
        end else begin
            o_result.channel_count   = 16'd0;
            o_result.rate_hz         = 32'd0;
            o_result.bits_per_sample = 16'd0;
            o_result.pcm_offset      = 32'd0;
            o_result.pcm_bytes       = 32'd0;
        end
    end

endmodule

// ----- hw/rtl/wav_header_chunk_parser_top.sv -----
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_top
// riff/wave header parser, one file byte per request, one result per file
// ----------------------------------------------------------------------------
// path: a byte is held in the input register; the result of the final byte
//   is formed from it combinationally and captured in the output register
// throughput: one byte per cycle; the only stall is a final byte whose result
//   finds the output register still held by the sink
// reset: synchronous, active low; clears handshake state and all parse state
// ----------------------------------------------------------------------------
module wav_header_chunk_parser_top
    import whcp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream, one file byte per request
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic         s_axis_tlast,   // is_last
    // result stream, one request per file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // [2:0] status, [18:3] channel_count,
                                         // [50:19] rate_hz,
                                         // [66:51] bits_per_sample,
                                         // [98:67] pcm_offset,
                                         // [130:99] pcm_bytes, rest zero
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // output register
    logic       r_out_vld;
    t_result    r_out;

    logic       walk_fire;
    t_summary   summary;
    t_result    result;

    // a byte moves on unless it is the final one and the result slot is busy
    assign walk_fire     = r_in_vld && (!r_in_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || walk_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // chunk walk and per-file state
    whcp_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (walk_fire),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_summary (summary)
    );

    // status and result fields from the state after the final byte
    whcp_result u_result (
        .i_summary (summary),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (walk_fire && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (walk_fire && r_in_last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0,
                            r_out.pcm_bytes,
                            r_out.pcm_offset,
                            r_out.bits_per_sample,
                            r_out.rate_hz,
                            r_out.channel_count,
                            r_out.status};

endmodule

// ----- test/wav_header_chunk_parser_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_header_chunk_parser_top_test
// streams wav files byte by byte into the parser and checks each file report
// against a cycle-free model of the riff/wave chunk walk
// ----------------------------------------------------------------------------
module wav_header_chunk_parser_top_test
    import whcp_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] file_byte
    logic         s_axis_tlast = 1'b0;    // is_last
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;           // [2:0] status, [18:3] channel_count,
                                          // [50:19] rate_hz,
                                          // [66:51] bits_per_sample,
                                          // [98:67] pcm_offset,
                                          // [130:99] pcm_bytes, rest zero

    wav_header_chunk_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // model of the chunk walk, advanced once per accepted request
    // ------------------------------------------------------------------------
    logic [31:0] walk_pos;
    t_phase      walk_phase;
    logic [63:0] hdr_bytes;      // id in the low word, size in the high word
    logic [2:0]  hdr_count;
    t_kind       walk_kind;
    logic [32:0] chunk_stop;     // one past the last body byte, 33 bits wide
    logic        magic_ok;
    logic        walk_halted;
    logic [15:0] new_code;
    logic [15:0] new_chans;
    logic [31:0] new_rate;
    logic [15:0] new_bits;
    logic [15:0] keep_chans;
    logic [31:0] keep_rate;
    logic [15:0] keep_bits;
    logic [31:0] pcm_off;
    logic [31:0] pcm_len;
    logic        pcm_seen;
    logic        fmt_bad;

    t_result     expected_reports[$];

    int          error_count = 0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    int          cycle_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic [7:0]  wav_bytes[$];

    function automatic void clear_walk();
        walk_pos    = '0;
        walk_phase  = PHASE_RIFF;
        hdr_bytes   = '0;
        hdr_count   = '0;
        walk_kind   = KIND_OTHER;
        chunk_stop  = '0;
        magic_ok    = 1'b1;
        walk_halted = 1'b0;
        new_code    = '0;
        new_chans   = '0;
        new_rate    = '0;
        new_bits    = '0;
        keep_chans  = '0;
        keep_rate   = '0;
        keep_bits   = '0;
        pcm_off     = '0;
        pcm_len     = '0;
        pcm_seen    = 1'b0;
        fmt_bad     = 1'b0;
    endfunction

    // a chunk whose whole body has arrived takes effect here
    function automatic void close_chunk();
        logic [32:0] body_start;
        body_start = chunk_stop - {1'b0, hdr_bytes[63:32]};
        if (walk_kind == KIND_FMT) begin
            keep_chans = new_chans;
            keep_rate  = new_rate;
            keep_bits  = new_bits;
            if (new_code != PCM_FORMAT) begin
                fmt_bad     = 1'b1;
                walk_halted = 1'b1;
            end
        end else if (walk_kind == KIND_DATA) begin
            pcm_off  = body_start[31:0];
            pcm_len  = hdr_bytes[63:32];
            pcm_seen = 1'b1;
        end
    endfunction

    task automatic parse_wav_byte(input logic [7:0] b, input logic last);
        logic [31:0] p;
        logic [31:0] chunk_size;
        logic [32:0] body_off;
        t_status     st;
        t_result     want;
        p = walk_pos;
        if (!walk_halted) begin
            case (walk_phase)
                PHASE_RIFF: begin
                    if (p < 32'd4) begin
                        if (b != ID_RIFF[8*p[1:0] +: 8]) magic_ok = 1'b0;
                    end else if (p >= 32'd8 && p < 32'd12) begin
                        if (b != ID_WAVE[8*p[1:0] +: 8]) magic_ok = 1'b0;
                    end
                    if (p >= 32'd11) begin
                        walk_phase = PHASE_HEADER;
                        hdr_count  = '0;
                    end
                end
                PHASE_HEADER: begin
                    if (hdr_count == 3'd0) hdr_bytes = '0;
                    hdr_bytes[8*hdr_count +: 8] = b;
                    if (hdr_count == 3'd7) begin
                        hdr_count  = '0;
                        chunk_size = hdr_bytes[63:32];
                        chunk_stop = {1'b0, p} + 33'd1 + {1'b0, chunk_size};
                        if (hdr_bytes[31:0] == ID_FMT && chunk_size >= FMT_MIN_BYTES)
                            walk_kind = KIND_FMT;
                        else if (hdr_bytes[31:0] == ID_DATA)
                            walk_kind = KIND_DATA;
                        else
                            walk_kind = KIND_OTHER;
                        new_code  = '0;
                        new_chans = '0;
                        new_rate  = '0;
                        new_bits  = '0;
                        // an empty chunk counts as soon as its header is in
                        if (chunk_size == 32'd0) close_chunk();
                        else walk_phase = PHASE_BODY;
                    end else begin
                        hdr_count = hdr_count + 3'd1;
                    end
                end
                PHASE_BODY: begin
                    chunk_size = hdr_bytes[63:32];
                    body_off   = {1'b0, p} - (chunk_stop - {1'b0, chunk_size});
                    if (walk_kind == KIND_FMT && body_off < 33'd16) begin
                        case (body_off[3:0])
                            4'd0:  new_code[7:0]   = b;
                            4'd1:  new_code[15:8]  = b;
                            4'd2:  new_chans[7:0]  = b;
                            4'd3:  new_chans[15:8] = b;
                            4'd4:  new_rate[7:0]   = b;
                            4'd5:  new_rate[15:8]  = b;
                            4'd6:  new_rate[23:16] = b;
                            4'd7:  new_rate[31:24] = b;
                            4'd14: new_bits[7:0]   = b;
                            4'd15: new_bits[15:8]  = b;
                            default: ;
                        endcase
                    end
                    if ({1'b0, p} + 33'd1 == chunk_stop) begin
                        close_chunk();
                        walk_phase = chunk_size[0] ? PHASE_PAD : PHASE_HEADER;
                    end
                end
                default: walk_phase = PHASE_HEADER;
            endcase
        end
        walk_pos = p + 32'd1;
        if (last) begin
            if ({1'b0, p} + 33'd1 < {1'b0, MIN_FILE_BYTES}) st = ST_SHORT;
            else if (!magic_ok)                              st = ST_BAD_MAGIC;
            else if (fmt_bad)                                st = ST_NOT_PCM;
            else if (!pcm_seen || pcm_len == 32'd0)          st = ST_NO_DATA;
            else if (keep_bits != PCM_BITS)                  st = ST_BAD_BITS;
            else                                             st = ST_OK;
            want = '0;
            want.status = st;
            if (st == ST_OK) begin
                want.channel_count   = keep_chans;
                want.rate_hz         = keep_rate;
                want.bits_per_sample = keep_bits;
                want.pcm_offset      = pcm_off;
                want.pcm_bytes       = pcm_len;
            end
            expected_reports.push_back(want);
            clear_walk();
        end
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_report(input logic [135:0] bus);
        t_result want;
        if (expected_reports.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, actual %h",
                     $time, bus);
            error_count++;
            return;
        end
        want = expected_reports.pop_front();
        check_field("status", 32'(want.status), 32'(bus[2:0]));
        check_field("channel_count", 32'(want.channel_count), 32'(bus[18:3]));
        check_field("rate_hz", want.rate_hz, bus[50:19]);
        check_field("bits_per_sample", 32'(want.bits_per_sample), 32'(bus[66:51]));
        check_field("pcm_offset", want.pcm_offset, bus[98:67]);
        check_field("pcm_bytes", want.pcm_bytes, bus[130:99]);
        check_field("padding", 32'd0, 32'(bus[135:131]));
    endtask

    // both handshakes sampled at the edge, before any driver update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) parse_wav_byte(s_axis_tdata, s_axis_tlast);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("wav_header_chunk_parser_top verification failed");
            $finish;
        end
    end

    // idle length: none unless the busy percentage hits, then mostly short, now and then long
    function automatic int pick_idle(input int busy_pct);
        int r;
        if ($urandom_range(0, 99) >= busy_pct) return 0;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // sink side back pressure
    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_idle(sink_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // file building and sending
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic last);
        int idle;
        idle = pick_idle(src_idle_pct);
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // sends the first n built bytes as one file, the nth marked last
    task automatic send_prefix(input int n);
        for (int i = 0; i < n; i++) send_byte(wav_bytes[i], i == n - 1);
        files_sent++;
    endtask

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void start_file();
        wav_bytes.delete();
        put_le(ID_RIFF, 4);
        put_le($urandom, 4);
        put_le(ID_WAVE, 4);
    endfunction

    // header, random body and the pad byte after an odd size
    function automatic void put_chunk(input logic [31:0] id, input int size);
        put_le(id, 4);
        put_le(size, 4);
        repeat (size) wav_bytes.push_back(8'($urandom));
        if (size % 2 == 1) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_fmt(input int size, input logic [15:0] code,
                                    input logic [15:0] chans, input logic [31:0] rate,
                                    input logic [15:0] bits);
        put_le(ID_FMT, 4);
        put_le(size, 4);
        if (size >= 16) begin
            put_le(32'(code), 2);
            put_le(32'(chans), 2);
            put_le(rate, 4);
            put_le($urandom, 4);    // byte rate, not looked at
            put_le($urandom, 2);    // block align, not looked at
            put_le(32'(bits), 2);
            repeat (size - 16) wav_bytes.push_back(8'($urandom));
        end else begin
            repeat (size) wav_bytes.push_back(8'($urandom));
        end
        if (size % 2 == 1) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_random_fmt();
        int r;
        int size;
        r = $urandom_range(0, 99);
        if (r < 70)      size = 16;
        else if (r < 85) size = $urandom_range(17, 24);
        else             size = $urandom_range(0, 15);
        put_fmt(size,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : PCM_FORMAT,
                ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 2)) : 16'($urandom),
                $urandom,
                ($urandom_range(0, 6) == 0) ? 16'($urandom) : PCM_BITS);
    endfunction

    function automatic void put_random_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)       put_chunk(ID_DATA, 0);
        else if (r < 85) put_chunk(ID_DATA, $urandom_range(1, 12));
        else             put_chunk(ID_DATA, $urandom_range(13, 40));
    endfunction

    function automatic void put_random_chunk();
        case ($urandom_range(0, 3))
            0: put_random_fmt();
            1: put_random_data();
            2: put_chunk(32'h5453_494C, $urandom_range(0, 9));   // "LIST"
            default: put_chunk($urandom, $urandom_range(0, 9));
        endcase
    endfunction

    // flips one bit of one of the eight magic bytes
    function automatic void spoil_magic(input int which);
        int pos;
        pos = (which < 4) ? which : which + 4;
        wav_bytes[pos] = wav_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // length boundary around 44 bytes, short beating every other error
    task automatic test_short_files();
        wav_bytes.delete();
        wav_bytes.push_back(8'hFF);
        send_prefix(1);
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_le(ID_DATA, 4);
        put_le(32'd0, 4);
        send_prefix(43);                       // short
        send_prefix(44);                       // long enough, empty data
        spoil_magic(2);
        send_prefix(30);                       // short and bad magic
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_chunk(ID_DATA, 2);
        send_prefix(wav_bytes.size());         // smallest good file
    endtask

    // every magic byte spoiled once; bad magic wins over a bad format
    task automatic test_magic();
        for (int i = 0; i < 8; i++) begin
            start_file();
            put_fmt(16, (i == 7) ? 16'd3 : PCM_FORMAT, 16'd1, 32'd8000, PCM_BITS);
            put_chunk(ID_DATA, 4);
            spoil_magic(i);
            send_prefix(wav_bytes.size());
        end
    endtask

    task automatic test_fmt_chunks();
        // field extremes
        start_file();
        put_fmt(16, PCM_FORMAT, 16'hFFFF, 32'hFFFF_FFFF, PCM_BITS);
        put_chunk(ID_DATA, 2);
        send_prefix(wav_bytes.size());
        start_file();
        put_fmt(16, PCM_FORMAT, 16'h0000, 32'h0000_0000, PCM_BITS);
        put_chunk(ID_DATA, 6);
        send_prefix(wav_bytes.size());
        // not pcm, also ahead of bad bits and missing data
        start_file();
        put_fmt(16, 16'hFFFF, 16'd2, 32'd48000, 16'd8);
        send_prefix(wav_bytes.size());
        // bad format stops the walk, the later good fmt is never seen
        start_file();
        put_fmt(16, 16'd0, 16'd2, 32'd48000, PCM_BITS);
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd48000, PCM_BITS);
        put_chunk(ID_DATA, 4);
        send_prefix(wav_bytes.size());
        // short fmt is skipped like any other chunk
        start_file();
        put_fmt(14, 16'd3, 16'd2, 32'd48000, PCM_BITS);
        put_fmt(18, PCM_FORMAT, 16'd1, 32'd22050, PCM_BITS);
        put_chunk(ID_DATA, 4);
        send_prefix(wav_bytes.size());
        start_file();
        put_fmt(15, PCM_FORMAT, 16'd2, 32'd48000, PCM_BITS);
        put_chunk(ID_DATA, 4);
        send_prefix(wav_bytes.size());         // no fmt kept, bits read as zero
        // the last counted fmt wins
        start_file();
        put_fmt(17, PCM_FORMAT, 16'd6, 32'd96000, 16'd24);
        put_fmt(16, PCM_FORMAT, 16'd3, 32'd32000, PCM_BITS);
        put_chunk(ID_DATA, 8);
        send_prefix(wav_bytes.size());
        // bits not 16
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd1, 32'd8000, 16'hFFFF);
        put_chunk(ID_DATA, 3);
        send_prefix(wav_bytes.size());
        // a bad fmt cut off by the final byte never counts
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_chunk(ID_DATA, 4);
        put_fmt(16, 16'd3, 16'd2, 32'd44100, PCM_BITS);
        send_prefix(wav_bytes.size() - 6);
    endtask

    task automatic test_data_chunks();
        // no data chunk at all
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_chunk(32'h5453_494C, 6);
        send_prefix(wav_bytes.size());
        // data ahead of fmt, empty chunk and odd chunk with pad in between
        start_file();
        put_chunk(ID_DATA, 5);
        put_chunk(32'h6B6E_756A, 0);
        put_chunk(32'h6B6E_756A, 3);
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        send_prefix(wav_bytes.size());
        // the last data chunk wins, even when it is empty
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_chunk(ID_DATA, 4);
        put_chunk(ID_DATA, 7);
        send_prefix(wav_bytes.size() - 1);     // pad missing at the end
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_chunk(ID_DATA, 4);
        put_chunk(ID_DATA, 0);
        send_prefix(wav_bytes.size());
        // data body cut off, then a cut header
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_chunk(ID_DATA, 2);
        put_le(ID_DATA, 4);
        put_le(32'd100, 4);
        repeat (10) wav_bytes.push_back(8'($urandom));
        send_prefix(wav_bytes.size());
        send_prefix(wav_bytes.size() - 14);
        // a body running past the end of any file
        start_file();
        put_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
        put_le(ID_DATA, 4);
        put_le(32'hFFFF_FFFF, 4);
        repeat (5) wav_bytes.push_back(8'($urandom));
        send_prefix(wav_bytes.size());
    endtask

    // mostly well-formed files with random content, some noise and cut files
    task automatic test_random_files();
        int shape;
        while (bytes_sent < 1950) begin
            if ($urandom_range(0, 3) == 0) begin
                src_idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
                sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            end
            shape = $urandom_range(0, 99);
            if (shape < 12) begin
                wav_bytes.delete();
                repeat ($urandom_range(1, 60)) wav_bytes.push_back(8'($urandom));
            end else if (shape < 25) begin
                start_file();
                repeat ($urandom_range(1, 5)) put_random_chunk();
            end else begin
                start_file();
                if ($urandom_range(0, 2) == 0) put_random_chunk();
                put_random_fmt();
                if ($urandom_range(0, 3) == 0) put_random_chunk();
                if ($urandom_range(0, 9) != 0) put_random_data();
                if ($urandom_range(0, 3) == 0) put_random_chunk();
            end
            if (wav_bytes.size() >= 12 && $urandom_range(0, 19) == 0)
                spoil_magic($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) send_prefix($urandom_range(1, wav_bytes.size()));
            else send_prefix(wav_bytes.size());
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_walk();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 20;
        sink_stall_pct = 20;
        test_short_files();
        test_magic();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_fmt_chunks();
        src_idle_pct   = 35;
        sink_stall_pct = 50;
        test_data_chunks();
        test_random_files();
        s_axis_tvalid <= 1'b0;

        // drain, then allow the output register to settle
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("wav_header_chunk_parser_top verification clean");
        end else begin
            $display("wav_header_chunk_parser_top verification failed");
        end
        $finish;
    end

endmodule
